### design/kfd_pkg.sv
// kfd_pkg: shared types and constants for the kiss frame deframer
// byte codes, byte classes, result kinds and the beat structs between parts
// no dependencies
`timescale 1ns / 1ps

package kfd_pkg;

    // kiss special bytes
    localparam logic [7:0] KB_FEND  = 8'hC0;
    localparam logic [7:0] KB_FESC  = 8'hDB;
    localparam logic [7:0] KB_TFEND = 8'hDC;
    localparam logic [7:0] KB_TFESC = 8'hDD;

    // width of the frame length field
    localparam int LEN_W = 10;

    // class of one received byte, worked out by the front part
    typedef enum logic [2:0] {
        CLS_FEND,
        CLS_FESC,
        CLS_TFEND,
        CLS_TFESC,
        CLS_OTHER
    } t_byte_class;

    // result kinds as they leave the block
    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    // classified byte passed from front to back
    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  rx_byte;
    } t_token;

    // one result beat
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] frame_length;
    } t_result;

endpackage

### design/kiss_frame_deframer.sv
// kiss_frame_deframer: top level, kiss stream in, decoded result beats out
// depends on kfd_pkg, kfd_front, kfd_queue, kfd_back
//
//   channel | handshake         | payload
//   --------+-------------------+------------------------------------------
//   input   | push / full       | i_rx_byte
//   result  | empty / pop       | o_result_kind, o_out_byte, o_frame_length
//
// one byte per cycle sustained while the consumer keeps popping results
// a byte waits in the token queue, its result in the result queue ahead of the ports
// full rises only when the two-entry token queue backs up behind the result queue
// synchronous active-low reset clears frame state, queues and the overflow latch
// after an overflow error bytes are still taken and dropped until reset
`timescale 1ns / 1ps

module kiss_frame_deframer #(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic [9:0] o_frame_length
);

    localparam int QUEUE_DEPTH = 2;

    logic             tok_push;
    logic             tok_full;
    logic             tok_empty;
    logic             tok_pop;
    kfd_pkg::t_token  tok_in;
    kfd_pkg::t_token  tok_out;
    logic             res_push;
    logic             res_full;
    kfd_pkg::t_result res_in;
    kfd_pkg::t_result res_out;

    // byte intake and classification
    kfd_front u_front (
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .i_tok_full (tok_full),
        .o_full     (full),
        .o_tok_push (tok_push),
        .o_token    (tok_in)
    );

    // token queue between front and back
    kfd_queue #(
        .WIDTH ($bits(kfd_pkg::t_token)),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_data  (tok_out),
        .o_empty (tok_empty)
    );

    // deframing
    kfd_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_token     (tok_out),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    // result queue facing the consumer
    kfd_queue #(
        .WIDTH ($bits(kfd_pkg::t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    // result fields
    assign o_result_kind  = res_out.kind;
    assign o_out_byte     = res_out.out_byte;
    assign o_frame_length = res_out.frame_length;

endmodule

### design/kfd_queue.sv
// kfd_queue: small first-word-fall-through queue held in flip-flops
// used between front and back and on the result side; no dependencies
`timescale 1ns / 1ps

module kfd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2    // power of two, at least 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    // handshake qualifiers
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    // count follows a lone push
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count missed a push");

    // write and read pointers agree with the count
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == PTR_W'(r_count))
        else $error("queue pointers out of step with count");
`endif

endmodule

### design/kfd_front.sv
// kfd_front: accepts raw bytes and tags each with its kiss byte class
// depends on kfd_pkg
`timescale 1ns / 1ps

module kfd_front (
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_tok_full,
    output logic          o_full,
    output logic          o_tok_push,
    output kfd_pkg::t_token o_token
);

    // accept whenever the token queue has room
    assign o_full     = i_tok_full;
    assign o_tok_push = i_push && !i_tok_full;

    // byte classification
    always_comb begin
        o_token.rx_byte = i_rx_byte;
        unique case (i_rx_byte)
            kfd_pkg::KB_FEND:  o_token.cls = kfd_pkg::CLS_FEND;
            kfd_pkg::KB_FESC:  o_token.cls = kfd_pkg::CLS_FESC;
            kfd_pkg::KB_TFEND: o_token.cls = kfd_pkg::CLS_TFEND;
            kfd_pkg::KB_TFESC: o_token.cls = kfd_pkg::CLS_TFESC;
            default:           o_token.cls = kfd_pkg::CLS_OTHER;
        endcase
    end

endmodule

### design/kfd_back.sv
// kfd_back: frame state, unescaping, byte count and overflow latch
// takes classified bytes and pushes result beats; depends on kfd_pkg
`timescale 1ns / 1ps

module kfd_back #(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  kfd_pkg::t_token  i_token,
    output logic             o_tok_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output kfd_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME_BYTES - 1);

    logic             r_in_frame,   n_in_frame;
    logic             r_expect_cmd, n_expect_cmd;
    logic             r_escape,     n_escape;
    logic [CNT_W-1:0] r_count,      n_count;
    logic             r_error,      n_error;
    logic             data_beat;
    logic [7:0]       data_val;
    logic [31:0]      count_wide;

    assign count_wide = 32'(r_count);

    // deframing decisions for the beat at the head of the token queue
    always_comb begin
        n_in_frame   = r_in_frame;
        n_expect_cmd = r_expect_cmd;
        n_escape     = r_escape;
        n_count      = r_count;
        n_error      = r_error;
        o_res_push   = 1'b0;
        o_result     = '{kind: kfd_pkg::KIND_CMD, out_byte: 8'h00,
                         frame_length: '0};
        data_beat    = 1'b0;
        data_val     = i_token.rx_byte;
        o_tok_pop    = i_tok_valid && !i_res_full;

        if (o_tok_pop && !r_error) begin
            if (!r_in_frame) begin
                // hunting: only a frame mark matters
                if (i_token.cls == kfd_pkg::CLS_FEND) begin
                    n_in_frame   = 1'b1;
                    n_expect_cmd = 1'b1;
                    n_escape     = 1'b0;
                    n_count      = '0;
                end
            end else if (i_token.cls == kfd_pkg::CLS_FEND) begin
                if (r_count != '0) begin
                    // close the frame with its length
                    o_res_push            = 1'b1;
                    o_result.kind         = kfd_pkg::KIND_END;
                    o_result.frame_length = count_wide[kfd_pkg::LEN_W-1:0];
                    n_in_frame            = 1'b0;
                    n_expect_cmd          = 1'b0;
                    n_escape              = 1'b0;
                    n_count               = '0;
                end else begin
                    // empty frame restarts
                    n_in_frame   = 1'b1;
                    n_expect_cmd = 1'b1;
                    n_escape     = 1'b0;
                    n_count      = '0;
                end
            end else if (r_expect_cmd) begin
                n_expect_cmd      = 1'b0;
                o_res_push        = 1'b1;
                o_result.kind     = kfd_pkg::KIND_CMD;
                o_result.out_byte = i_token.rx_byte;
            end else if (r_escape) begin
                n_escape  = 1'b0;
                data_beat = 1'b1;
                case (i_token.cls)
                    kfd_pkg::CLS_TFEND: data_val = kfd_pkg::KB_FEND;
                    kfd_pkg::CLS_TFESC: data_val = kfd_pkg::KB_FESC;
                    default:            data_val = i_token.rx_byte;
                endcase
            end else if (i_token.cls == kfd_pkg::CLS_FESC) begin
                n_escape = 1'b1;
            end else begin
                data_beat = 1'b1;
            end

            // payload byte or overflow
            if (data_beat) begin
                o_res_push = 1'b1;
                if (r_count == CNT_LAST) begin
                    n_error       = 1'b1;
                    o_result.kind = kfd_pkg::KIND_ERROR;
                end else begin
                    n_count           = r_count + CNT_W'(1);
                    o_result.kind     = kfd_pkg::KIND_DATA;
                    o_result.out_byte = data_val;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_expect_cmd <= 1'b0;
            r_escape     <= 1'b0;
            r_count      <= '0;
            r_error      <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_expect_cmd <= n_expect_cmd;
            r_escape     <= n_escape;
            r_count      <= n_count;
            r_error      <= n_error;
        end
    end

`ifndef NO_ASSERTIONS
    // overflow latch holds until reset
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> r_error)
        else $error("overflow latch dropped");

    // an error beat always sets the latch and only once
    a_error_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_result.kind == kfd_pkg::KIND_ERROR)
            |-> !r_error ##1 r_error)
        else $error("error beat without latch");

    // pending escape only inside a frame past its command byte
    a_escape_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> (r_in_frame && !r_expect_cmd))
        else $error("escape pending outside payload");

    // no beat is produced once latched
    a_quiet_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |-> !o_res_push)
        else $error("result after overflow");
`endif

endmodule

### verif/tb_kiss_frame_deframer.sv
// tb_kiss_frame_deframer: self-checking bench for the kiss frame deframer
// raw kiss bytes go in on the push side, decoded beats are checked on the pop side
// depends on kfd_pkg and kiss_frame_deframer
`timescale 1ns / 1ps

module tb_kiss_frame_deframer;

    localparam int MAX_BYTES   = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 150;
    localparam int SETTLE      = 20;
    localparam int MAX_SHOWN   = 10;
    localparam int FRAME_ITEMS = 320;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    logic [7:0] i_rx_byte = 8'h00;
    logic       empty;
    logic       pop       = 1'b0;
    logic [1:0] o_result_kind;
    logic [7:0] o_out_byte;
    logic [9:0] o_frame_length;

    kiss_frame_deframer #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_out_byte     (o_out_byte),
        .o_frame_length (o_frame_length)
    );

    // raw bytes waiting to be sent and decoded beats waiting to arrive
    logic [7:0]       stream_q[$];
    kfd_pkg::t_result decoded_q[$];

    // decoder state tracked alongside the block
    logic dec_in_frame = 1'b0;
    logic dec_want_cmd = 1'b0;
    logic dec_escaped  = 1'b0;
    logic dec_dead     = 1'b0;
    int   dec_count    = 0;

    // bookkeeping
    int n_pushed    = 0;
    int n_popped    = 0;
    int n_mismatch  = 0;
    int n_cmds      = 0;
    int n_payload   = 0;
    int n_frames    = 0;
    int n_overflows = 0;
    int full_cycles = 0;
    int idle_cycles = 0;
    int tx_wait     = 0;
    int rx_wait     = 0;
    int hold_left   = 0;
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic kfd_pkg::t_result make_beat(kfd_pkg::t_kind k, logic [7:0] b,
                                                   int len);
        kfd_pkg::t_result r;
        r.kind         = k;
        r.out_byte     = b;
        r.frame_length = len[kfd_pkg::LEN_W-1:0];
        return r;
    endfunction

    task automatic start_frame();
        dec_in_frame = 1'b1;
        dec_want_cmd = 1'b1;
        dec_escaped  = 1'b0;
        dec_count    = 0;
    endtask

    // kiss decoding of one accepted byte, queueing the beat it yields
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        if (dec_dead) begin
            // latched overflow: everything dropped
        end else if (!dec_in_frame) begin
            if (b == kfd_pkg::KB_FEND)
                start_frame();
        end else if (b == kfd_pkg::KB_FEND) begin
            if (dec_count != 0) begin
                decoded_q.push_back(make_beat(kfd_pkg::KIND_END, 8'h00, dec_count));
                dec_in_frame = 1'b0;
                dec_want_cmd = 1'b0;
                dec_escaped  = 1'b0;
                dec_count    = 0;
            end else begin
                start_frame();
            end
        end else if (dec_want_cmd) begin
            dec_want_cmd = 1'b0;
            decoded_q.push_back(make_beat(kfd_pkg::KIND_CMD, b, 0));
        end else if (!dec_escaped && b == kfd_pkg::KB_FESC) begin
            dec_escaped = 1'b1;
        end else begin
            v = b;
            if (dec_escaped) begin
                dec_escaped = 1'b0;
                if (b == kfd_pkg::KB_TFEND)
                    v = kfd_pkg::KB_FEND;
                else if (b == kfd_pkg::KB_TFESC)
                    v = kfd_pkg::KB_FESC;
            end
            if (dec_count + 1 == MAX_BYTES) begin
                dec_dead = 1'b1;
                decoded_q.push_back(make_beat(kfd_pkg::KIND_ERROR, 8'h00, 0));
            end else begin
                dec_count++;
                decoded_q.push_back(make_beat(kfd_pkg::KIND_DATA, v, 0));
            end
        end
    endtask

    // stimulus helpers
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return kfd_pkg::KB_FEND;
            1: return kfd_pkg::KB_FESC;
            2: return kfd_pkg::KB_TFEND;
            3: return kfd_pkg::KB_TFESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = pick_byte(); while (b == kfd_pkg::KB_FEND);
        return b;
    endfunction

    function automatic int draw_gap(input bit no_gap);
        return no_gap ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic add(input logic [7:0] b);
        stream_q.push_back(b);
    endtask

    // one payload value, escaped or bare, never a frame mark
    task automatic put_payload(input int esc_pct);
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < esc_pct / 3) begin
            add(kfd_pkg::KB_FESC);
            add(kfd_pkg::KB_TFEND);
        end else if (r < 2 * esc_pct / 3) begin
            add(kfd_pkg::KB_FESC);
            add(kfd_pkg::KB_TFESC);
        end else if (r < esc_pct) begin
            add(kfd_pkg::KB_FESC);
            add(pick_plain());
        end else begin
            do b = pick_plain(); while (b == kfd_pkg::KB_FESC);
            add(b);
        end
    endtask

    // a frame with random content; now and then restarted, cut short or left open
    task automatic gen_frame(input bit closed);
        int n;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
            add(kfd_pkg::KB_FEND);
        if ($urandom_range(0, 4) == 0) begin
            add(pick_plain());
            add(kfd_pkg::KB_FEND);
        end
        add(pick_plain());
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(20, 120);
            default: n = $urandom_range(1, 12);
        endcase
        repeat (n) put_payload(45);
        if ($urandom_range(0, 9) == 0)
            add(kfd_pkg::KB_FESC);
        if (closed)
            add(kfd_pkg::KB_FEND);
    endtask

    // sender: one byte per beat, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                deframe_byte(i_rx_byte);
                n_pushed++;
                if (n_pushed % 64 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
            end
            if (push && full)
                full_cycles++;
            if (!push || !full) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    push <= 1'b0;
                end else if (stream_q.size() != 0) begin
                    push      <= 1'b1;
                    i_rx_byte <= stream_q.pop_front();
                    tx_wait = draw_gap(tx_burst || hold_left > 0);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each beat with the oldest decoded one
    always @(posedge i_clk) begin
        kfd_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_popped++;
                case (kfd_pkg::t_kind'(o_result_kind))
                    kfd_pkg::KIND_CMD:  n_cmds++;
                    kfd_pkg::KIND_DATA: n_payload++;
                    kfd_pkg::KIND_END:  n_frames++;
                    default:            n_overflows++;
                endcase
                if (decoded_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN)
                        $display("[%0t] unexpected beat: kind %0d byte %02h len %0d",
                                 $time, o_result_kind, o_out_byte, o_frame_length);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_result_kind !== want.kind || o_out_byte !== want.out_byte ||
                        o_frame_length !== want.frame_length) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_SHOWN) begin
                            $display("[%0t] beat %0d: expected kind %0d byte %02h len %0d",
                                     $time, n_popped, want.kind, want.out_byte,
                                     want.frame_length);
                            $display("[%0t] beat %0d: got kind %0d byte %02h len %0d",
                                     $time, n_popped, o_result_kind, o_out_byte,
                                     o_frame_length);
                        end
                    end
                end
                rx_wait = draw_gap(rx_burst);
                if (n_popped % 64 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
                // long hold-off so the block backs up and raises full
                if (n_popped == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int frame_items;
        int before_len;

        // noise while hunting
        add(8'h00);
        add(8'hFF);
        add(kfd_pkg::KB_FESC);
        // repeated frame marks, then a command with no payload restarts
        add(kfd_pkg::KB_FEND);
        add(kfd_pkg::KB_FEND);
        add(8'h00);
        add(kfd_pkg::KB_FEND);
        // command and payload extremes, both escapes, escape of an ordinary byte
        add(8'hFF);
        add(8'hFF);
        add(8'h00);
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_TFEND);
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_TFESC);
        add(kfd_pkg::KB_FESC);
        add(8'h41);
        // bare transpose codes pass through
        add(kfd_pkg::KB_TFEND);
        add(kfd_pkg::KB_TFESC);
        // frame mark right after an escape closes the frame
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_FEND);
        // escape byte as command, then an escaped escape
        add(kfd_pkg::KB_FEND);
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_FESC);
        add(kfd_pkg::KB_FEND);

        // random frames, mostly well formed
        frame_items = 0;
        while (frame_items < FRAME_ITEMS) begin
            before_len = stream_q.size();
            gen_frame($urandom_range(0, 9) != 0);
            frame_items += stream_q.size() - before_len;
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 5)) add(pick_plain());
        end

        // one frame run up to overflow, then bytes that must be dropped
        add(kfd_pkg::KB_FEND);
        add(kfd_pkg::KB_FEND);
        add(pick_plain());
        repeat (MAX_BYTES) put_payload(6);
        repeat (8) add(pick_byte());
        add(kfd_pkg::KB_FEND);
        add(8'h55);
        add(kfd_pkg::KB_FEND);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (stream_q.size() != 0 || push || decoded_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        if (decoded_q.size() != 0) begin
            $display("%0d decoded beats never arrived", decoded_q.size());
            n_mismatch += decoded_q.size();
        end
        $display("%0d bytes in, %0d beats out: %0d commands, %0d payload bytes",
                 n_pushed, n_popped, n_cmds, n_payload);
        $display("%0d frame ends, %0d overflow, input held off %0d cycles, %0d mismatches",
                 n_frames, n_overflows, full_cycles, n_mismatch);
        if (n_mismatch == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
design/kfd_pkg.sv
design/kfd_queue.sv
design/kfd_front.sv
design/kfd_back.sv
design/kiss_frame_deframer.sv
verif/tb_kiss_frame_deframer.sv
